FILE: src/esrt_pkg.sv
package esrt_pkg;

    // Field widths of the request and result words
    localparam int unsigned COL_W   = 8;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned VAL_W   = 64;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned BW_W    = 4;
    localparam int unsigned OCC_W   = 12;
    localparam int unsigned STAT_W  = 2;

    // Saturation limit of the occupancy count
    localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

    // Request kinds carried on s_tuser
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Register indexes, taken from paddr[2]
    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic REG_SLOTS       = 1'b1;

    // Register reset values
    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RST = 9'd256;
    localparam logic [BW_W-1:0]   SLOTS_RST       = 4'd8;

    // One slot of a row: column number and complex value
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] re;
        logic [VAL_W-1:0] im;
    } slot_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic load;
        logic exec;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
    } stat_t;

endpackage

FILE: src/esrt_ctrl.sv
module esrt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output esrt_pkg::cmd_t   cmd,
    input  esrt_pkg::stat_t  stat
);
    import esrt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_ready;

    // Take a new word only when idle and the output slot is free or draining
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && in_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted word not followed by execute cycle");

    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> m_tvalid)
        else $error("execute cycle did not present a result");

    a_exec_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> !out_valid_reg)
        else $error("execute cycle would overwrite a pending result");

endmodule

FILE: src/esrt_dp.sv
module esrt_dp #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_SLOTS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  esrt_pkg::cmd_t              cmd,
    output esrt_pkg::stat_t             stat,
    input  logic [esrt_pkg::SIZE_W-1:0] matrix_size,
    input  logic [esrt_pkg::BW_W-1:0]   slots_in_use,
    input  logic                        req_type,
    input  logic [esrt_pkg::IDX_W-1:0]  row_index,
    input  logic [esrt_pkg::COL_W-1:0]  col_index,
    input  logic [esrt_pkg::VAL_W-1:0]  write_real,
    input  logic [esrt_pkg::VAL_W-1:0]  write_imag,
    output logic [esrt_pkg::VAL_W-1:0]  read_real,
    output logic [esrt_pkg::VAL_W-1:0]  read_imag,
    output logic                        hit,
    output logic [esrt_pkg::STAT_W-1:0] status,
    output logic [esrt_pkg::OCC_W-1:0]  occupied_count
);
    import esrt_pkg::*;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
    localparam int SIZE_CAP = (MAX_ROWS < 511) ? MAX_ROWS : 511;
    localparam int SLOT_CAP = (MAX_SLOTS < 15) ? MAX_SLOTS : 15;

    // Row store: slot array plus fill count (slots fill from the bottom up)
    slot_t [MAX_SLOTS-1:0] slot_mem [MAX_ROWS];
    logic  [CNT_W-1:0]     fill_mem [MAX_ROWS];

    slot_t [MAX_SLOTS-1:0] rd_slots_reg;
    logic  [CNT_W-1:0]     rd_fill_reg;

    logic                  type_reg;
    logic [IDX_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic [VAL_W-1:0]      wre_reg;
    logic [VAL_W-1:0]      wim_reg;
    logic [ROW_W-1:0]      row_addr_reg;

    logic [ROW_W-1:0]      clr_row_reg;
    logic [OCC_W-1:0]      occ_reg, occ_next;

    logic [VAL_W-1:0]      rre_reg, rre_next;
    logic [VAL_W-1:0]      rim_reg, rim_next;
    logic                  hit_reg, hit_next;
    logic [STAT_W-1:0]     status_reg, status_next;

    logic [SIZE_W-1:0]     eff_size;
    logic [BW_W-1:0]       eff_bw;
    logic                  in_range;
    logic [MAX_SLOTS-1:0]  match;
    logic                  found;
    logic [SLOT_W-1:0]     hit_idx;
    logic                  empty;
    logic [SLOT_W-1:0]     at_idx;
    slot_t [MAX_SLOTS-1:0] wr_slots;
    logic  [CNT_W-1:0]     wr_fill;
    logic                  mem_wr;

    // Clamp the configuration to the built size
    always_comb begin
        if (matrix_size > SIZE_W'(SIZE_CAP)) begin
            eff_size = SIZE_W'(SIZE_CAP);
        end else begin
            eff_size = matrix_size;
        end
        if (slots_in_use == '0) begin
            eff_bw = BW_W'(1);
        end else if (slots_in_use > BW_W'(SLOT_CAP)) begin
            eff_bw = BW_W'(SLOT_CAP);
        end else begin
            eff_bw = slots_in_use;
        end
    end

    // Capture the request with the row read
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            type_reg     <= req_type;
            row_reg      <= row_index;
            col_reg      <= col_index;
            wre_reg      <= write_real;
            wim_reg      <= write_imag;
            row_addr_reg <= ROW_W'(row_index);
        end
    end

    // Store: clear pass, write-back and registered row read
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            fill_mem[clr_row_reg] <= '0;
        end else if (mem_wr) begin
            slot_mem[row_addr_reg] <= wr_slots;
            fill_mem[row_addr_reg] <= wr_fill;
        end
        if (cmd.load) begin
            rd_slots_reg <= slot_mem[ROW_W'(row_index)];
            rd_fill_reg  <= fill_mem[ROW_W'(row_index)];
        end
    end

    // Advance the clear pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_row_reg <= '0;
        end else if (cmd.clr_step && !stat.clr_done) begin
            clr_row_reg <= clr_row_reg + 1'b1;
        end
    end

    assign stat.clr_done = (clr_row_reg == ROW_W'(MAX_ROWS - 1));

    assign in_range = ({1'b0, row_reg} < eff_size) && ({1'b0, col_reg} < eff_size);

    // Compare all searched slots against the column in parallel
    always_comb begin
        for (int k = 0; k < MAX_SLOTS; k++) begin
            match[k] = (k < int'(eff_bw)) && (k < int'(rd_fill_reg)) &&
                       (rd_slots_reg[k].col == col_reg);
        end
    end

    // Pick the lowest matching slot
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            if (match[k]) begin
                found   = 1'b1;
                hit_idx = SLOT_W'(k);
            end
        end
    end

    // Choose the target slot and build the updated row
    always_comb begin
        empty    = int'(rd_fill_reg) < int'(eff_bw);
        if (found) begin
            at_idx = hit_idx;
        end else if (empty) begin
            at_idx = SLOT_W'(rd_fill_reg);
        end else begin
            at_idx = SLOT_W'(eff_bw - BW_W'(1));
        end
        wr_slots         = rd_slots_reg;
        wr_slots[at_idx] = '{col: col_reg, re: wre_reg, im: wim_reg};
        wr_fill          = rd_fill_reg;
        if (!found && empty) begin
            wr_fill = rd_fill_reg + 1'b1;
        end
    end

    assign mem_wr = cmd.exec && in_range && (type_reg == REQ_WRITE);

    // Result and occupancy
    always_comb begin
        rre_next    = '0;
        rim_next    = '0;
        hit_next    = 1'b0;
        status_next = STAT_DONE;
        occ_next    = occ_reg;
        if (!in_range) begin
            status_next = STAT_RANGE;
        end else if (type_reg == REQ_READ) begin
            if (found) begin
                rre_next = rd_slots_reg[hit_idx].re;
                rim_next = rd_slots_reg[hit_idx].im;
                hit_next = 1'b1;
            end
        end else if (found) begin
            hit_next = 1'b1;
        end else if (empty) begin
            if (occ_reg != OCC_MAX) begin
                occ_next = occ_reg + 1'b1;
            end
        end else begin
            status_next = STAT_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.exec) begin
            occ_reg <= occ_next;
        end
    end

    // Hold the result until the next execute cycle
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rre_reg    <= rre_next;
            rim_reg    <= rim_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    assign read_real      = rre_reg;
    assign read_imag      = rim_reg;
    assign hit            = hit_reg;
    assign status         = status_reg;
    assign occupied_count = occ_reg;

    a_occ_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (occ_reg >= $past(occ_reg)))
        else $error("occupancy count decreased");

endmodule

FILE: src/ell_sparse_row_table.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: req_type; tdata: row, col, real, imag
// m_        out  m_tvalid/m_tready  tuser: hit, status; tdata: real, imag, count
// APB       in   psel/penable       reg 0 matrix_size @0x0, reg 1 slots_in_use @0x4
//
// For each request, the accept cycle reads the whole row word from
// the row store, the next cycle compares all slots at once and writes the row back.
// The result sits in an output register; a new request is taken only in a cycle
// where that register is empty or its word is being taken.
// After reset a clearing pass zeroes the row fill counts, during which s_tready
// stays low. A stalled result holds s_tready low until taken.
module ell_sparse_row_table #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_SLOTS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // row_index[7:0], col_index[15:8],
                                   // write_real[79:16], write_imag[143:80]
    input  logic         s_tuser,  // req_type[0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,  // read_real[63:0], read_imag[127:64],
                                   // occupied_count[139:128], zero[143:140]
    output logic [2:0]   m_tuser   // hit[0], status[2:1]
);
    import esrt_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [BW_W-1:0]   slots_reg;
    logic              cfg_wr;

    cmd_t              cmd;
    stat_t             stat;

    logic [VAL_W-1:0]  read_real;
    logic [VAL_W-1:0]  read_imag;
    logic              hit;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupied_count;

    // Register writes complete in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= MATRIX_SIZE_RST;
            slots_reg <= SLOTS_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MATRIX_SIZE: size_reg  <= pwdata[SIZE_W-1:0];
                REG_SLOTS:       slots_reg <= pwdata[BW_W-1:0];
                default:         size_reg  <= size_reg;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_MATRIX_SIZE: prdata = {{(32 - SIZE_W){1'b0}}, size_reg};
            REG_SLOTS:       prdata = {{(32 - BW_W){1'b0}}, slots_reg};
            default:         prdata = '0;
        endcase
    end

    esrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    esrt_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .matrix_size    (size_reg),
        .slots_in_use   (slots_reg),
        .req_type       (s_tuser),
        .row_index      (s_tdata[7:0]),
        .col_index      (s_tdata[15:8]),
        .write_real     (s_tdata[79:16]),
        .write_imag     (s_tdata[143:80]),
        .read_real      (read_real),
        .read_imag      (read_imag),
        .hit            (hit),
        .status         (status),
        .occupied_count (occupied_count)
    );

    assign m_tdata = {4'b0, occupied_count, read_imag, read_real};
    assign m_tuser = {status, hit};

endmodule

FILE: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import esrt_pkg::*;

    localparam int NUM_ROWS      = 256;
    localparam int NUM_SLOTS     = 8;
    localparam int STORE_DEPTH   = NUM_ROWS * NUM_SLOTS;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 230;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] re;
        logic [VAL_W-1:0] im;
    } row_request_t;

    typedef struct packed {
        logic [VAL_W-1:0]  re;
        logic [VAL_W-1:0]  im;
        logic              hit;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  count;
    } table_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata  = '0;  // row_index, col_index, write_real, write_imag
    logic         s_tuser  = 1'b0; // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;        // read_real, read_imag, occupied_count, zero pad
    logic [2:0]   m_tuser;        // hit, status

    // Shadow copy of the table and its registers
    logic              shadow_valid [STORE_DEPTH];
    logic [COL_W-1:0]  shadow_col   [STORE_DEPTH];
    logic [VAL_W-1:0]  shadow_re    [STORE_DEPTH];
    logic [VAL_W-1:0]  shadow_im    [STORE_DEPTH];
    logic [OCC_W-1:0]  shadow_count = '0;
    logic [SIZE_W-1:0] cfg_size     = MATRIX_SIZE_RST;
    logic [BW_W-1:0]   cfg_slots    = SLOTS_RST;

    table_result_t pending_accesses[$];
    int            error_count        = 0;
    int            sender_idle_pct    = 0;
    int            receiver_stall_pct = 0;
    int            quiet_cycles       = 0;

    ell_sparse_row_table #(
        .MAX_ROWS  (NUM_ROWS),
        .MAX_SLOTS (NUM_SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_col[i]   = '0;
            shadow_re[i]    = '0;
            shadow_im[i]    = '0;
        end
    end

    function automatic int eff_size();
        return (cfg_size > NUM_ROWS) ? NUM_ROWS : int'(cfg_size);
    endfunction

    // Apply one request to the shadow table and return the word it should produce
    function automatic table_result_t apply_to_table(row_request_t req);
        table_result_t res;
        int            bw;
        int            base;
        int            at;
        bit            found;
        bit            empty;
        res   = '0;
        found = 0;
        empty = 0;
        at    = 0;
        if (req.row >= eff_size() || req.col >= eff_size()) begin
            res.status = STAT_RANGE;
        end else begin
            bw   = (cfg_slots == 0) ? 1 : ((cfg_slots > NUM_SLOTS) ? NUM_SLOTS : cfg_slots);
            base = req.row * NUM_SLOTS;
            // Scan used slots in order, stop at first empty or matching slot
            for (int k = 0; k < bw; k++) begin
                if (!shadow_valid[base + k]) begin
                    empty = 1;
                    at    = base + k;
                    break;
                end
                if (shadow_col[base + k] == req.col) begin
                    found = 1;
                    at    = base + k;
                    break;
                end
            end
            if (req.kind == REQ_READ) begin
                if (found) begin
                    res.re  = shadow_re[at];
                    res.im  = shadow_im[at];
                    res.hit = 1'b1;
                end
            end else if (found) begin
                shadow_re[at] = req.re;
                shadow_im[at] = req.im;
                res.hit       = 1'b1;
            end else if (empty) begin
                shadow_valid[at] = 1'b1;
                shadow_col[at]   = req.col;
                shadow_re[at]    = req.re;
                shadow_im[at]    = req.im;
                if (shadow_count != OCC_MAX) begin
                    shadow_count = shadow_count + 1'b1;
                end
            end else begin
                // Row full: replace the last slot in use
                at             = base + bw - 1;
                shadow_col[at] = req.col;
                shadow_re[at]  = req.re;
                shadow_im[at]  = req.im;
                res.status     = STAT_FULL;
            end
        end
        res.count = shadow_count;
        return res;
    endfunction

    function automatic row_request_t make_request(logic kind, int row, int col,
                                                  logic [VAL_W-1:0] re,
                                                  logic [VAL_W-1:0] im);
        row_request_t req;
        req.kind = kind;
        req.row  = row[IDX_W-1:0];
        req.col  = col[COL_W-1:0];
        req.re   = re;
        req.im   = im;
        return req;
    endfunction

    // Mostly dense traffic on a few rows and columns, some edge and noise words
    function automatic row_request_t random_request();
        row_request_t req;
        int           span;
        int           pick;
        span     = eff_size();
        pick     = $urandom_range(0, 99);
        req.kind = ($urandom_range(0, 99) < 55) ? REQ_WRITE : REQ_READ;
        req.row  = IDX_W'($urandom_range(0, 255));
        req.col  = COL_W'($urandom_range(0, 255));
        req.re   = {$urandom, $urandom};
        req.im   = {$urandom, $urandom};
        if (span > 0 && pick < 65) begin
            req.row = IDX_W'($urandom_range(0, ((span < 12) ? span : 12) - 1));
            req.col = COL_W'($urandom_range(0, ((span < 14) ? span : 14) - 1));
        end else if (span > 0 && pick < 75) begin
            req.row = IDX_W'(span - 1);
            req.col = COL_W'((span < NUM_ROWS && $urandom_range(0, 1)) ? span : span - 1);
            if ($urandom_range(0, 1)) begin
                req.row = req.col;
                req.col = COL_W'(span - 1);
            end
        end
        return req;
    endfunction

    // Present one word, hold it until accepted, then record its outcome
    task automatic send_request(input row_request_t req);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.kind;
        s_tdata  <= {req.im, req.re, req.col, req.row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_accesses.push_back(apply_to_table(req));
    endtask

    // Drop valid and wait until every outstanding word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_accesses.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_MATRIX_SIZE) begin
            cfg_size = value[SIZE_W-1:0];
        end else begin
            cfg_slots = value[BW_W-1:0];
        end
        @(posedge aclk);
    endtask

    task automatic set_config(input int size_val, input int slots_val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_register(REG_MATRIX_SIZE, size_val);
        write_register(REG_SLOTS, slots_val);
    endtask

    task automatic test_basic_access();
        send_request(make_request(REQ_READ, 0, 0, '1, '1));
        send_request(make_request(REQ_WRITE, 0, 0, '1, '1));
        send_request(make_request(REQ_READ, 0, 0, '0, '0));
        send_request(make_request(REQ_WRITE, 0, 0, '0, '0));
        send_request(make_request(REQ_WRITE, 255, 255, 64'h8000_0000_0000_0001,
                                  64'h7FFF_FFFF_FFFF_FFFE));
        send_request(make_request(REQ_READ, 255, 255, '1, '1));
    endtask

    task automatic test_row_overflow();
        for (int c = 10; c < 10 + NUM_SLOTS; c++) begin
            send_request(make_request(REQ_WRITE, 1, c, {$urandom, $urandom},
                                      {$urandom, $urandom}));
        end
        send_request(make_request(REQ_WRITE, 1, 99, '1, '0));
        send_request(make_request(REQ_READ, 1, 99, '0, '0));
        send_request(make_request(REQ_READ, 1, 10 + NUM_SLOTS - 1, '0, '0));
    endtask

    task automatic test_bandwidth_bounds();
        // Narrowed bandwidth: slots past it stay occupied but unsearched
        set_config(NUM_ROWS, 2);
        send_request(make_request(REQ_READ, 1, 12, '0, '0));
        send_request(make_request(REQ_WRITE, 1, 50, '0, '1));
        // Zero bandwidth acts as one slot
        set_config(NUM_ROWS, 0);
        send_request(make_request(REQ_WRITE, 3, 7, '1, '0));
        send_request(make_request(REQ_WRITE, 3, 8, '0, '1));
        // Oversized values clamp to the maximum
        set_config(511, 15);
        send_request(make_request(REQ_READ, 1, 13, '0, '0));
    endtask

    task automatic test_size_bounds();
        set_config(0, NUM_SLOTS);
        send_request(make_request(REQ_READ, 0, 0, '0, '0));
        set_config(1, NUM_SLOTS);
        send_request(make_request(REQ_READ, 0, 1, '0, '0));
        send_request(make_request(REQ_WRITE, 1, 0, '1, '1));
        send_request(make_request(REQ_READ, 0, 0, '1, '1));
    endtask

    task automatic test_random_traffic();
        int sizes [8] = '{256, 16, 1, 511, 200, 4, 128, 256};
        int slots [8] = '{8, 4, 1, 15, 0, 8, 3, 1};
        int idles [4] = '{0, 85, 0, 21};
        int stalls[4] = '{0, 0, 85, 21};
        for (int p = 0; p < 8; p++) begin
            set_config(sizes[p], slots[p]);
            sender_idle_pct    = idles[p % 4];
            receiver_stall_pct = stalls[p % 4];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Hold off mid-phase until the pipeline is empty
                if (i == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_request(random_request());
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_access();
        test_row_overflow();
        test_bandwidth_bounds();
        test_size_bounds();
        test_random_traffic();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_accesses.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Check each returned word against the oldest outstanding one
    always @(posedge aclk) begin : result_check
        table_result_t want;
        table_result_t got;
        if (m_tvalid && m_tready) begin
            got.re     = m_tdata[63:0];
            got.im     = m_tdata[127:64];
            got.count  = m_tdata[139:128];
            got.hit    = m_tuser[0];
            got.status = m_tuser[2:1];
            if (pending_accesses.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected word: re=%h im=%h hit=%b status=%0d count=%0d",
                             got.re, got.im, got.hit, got.status, got.count);
                end
            end else begin
                want = pending_accesses.pop_front();
                if (got.re !== want.re || got.im !== want.im || got.hit !== want.hit ||
                    got.status !== want.status || got.count !== want.count) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch exp: re=%h im=%h hit=%b status=%0d count=%0d",
                                 want.re, want.im, want.hit, want.status, want.count);
                        $display("         got: re=%h im=%h hit=%b status=%0d count=%0d",
                                 got.re, got.im, got.hit, got.status, got.count);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Stop the run when nothing moves on any port for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
